// ===== rtl/core/circuit_depth_levelizer_core_defines.svh =====
`ifndef CIRCUIT_DEPTH_LEVELIZER_CORE_DEFINES_SVH
`define CIRCUIT_DEPTH_LEVELIZER_CORE_DEFINES_SVH

// implication checked on every rising clock edge, held off while reset is low
`define CDL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same check, only where the enable term holds
`define CDL_ASSERT_IF(lbl, en, prop, msg) \
    `CDL_ASSERT(lbl, (en) |-> (prop), msg)

`endif

// ===== rtl/core/cdl_pkg.sv =====
`default_nettype none

package cdl_pkg;

    localparam int QUBIT_SLOTS = 64;
    localparam int LEVEL_BITS  = 16;
    localparam int ADDR_W      = $clog2(QUBIT_SLOTS);

    localparam int QB_W  = 6;
    localparam int NQ_W  = 6;
    localparam int ERR_W = 2;
    localparam int OUT_W = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [NQ_W-1:0]       NQ_RESET  = NQ_W'(62);
    localparam logic [QB_W:0]         SLOTS_EXT = (QB_W + 1)'(QUBIT_SLOTS);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SAME  = 2'd2;

    typedef struct packed {
        logic capture;
        logic rd;
        logic calc;
        logic wr2;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic err_none;
        logic two;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/cdl_ctrl.sv =====
`default_nettype none
`include "circuit_depth_levelizer_core_defines.svh"

module cdl_ctrl import cdl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = i_status.err_none ? S_CALC : S_DONE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_status.two ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CDL_ASSERT(a_accept_to_rd, (i_in_valid && o_in_ready) |=> (r_state == S_RD), "no read after transfer")
    `CDL_ASSERT(a_done_holds, (r_state == S_DONE && !i_status.out_free) |=> (r_state == S_DONE), "result dropped while output busy")
    `CDL_ASSERT_IF(a_calc_after_rd, r_state == S_CALC, $past(r_state) == S_RD, "calc without read")

endmodule

`default_nettype wire

// ===== rtl/core/cdl_datapath.sv =====
`default_nettype none
`include "circuit_depth_levelizer_core_defines.svh"

module cdl_datapath import cdl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [NQ_W-1:0]   i_cfg_wdata,
    input  logic              i_two,
    input  logic [QB_W-1:0]   i_qa,
    input  logic [QB_W-1:0]   i_qb,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ERR_W-1:0]  o_err,
    output logic [OUT_W-1:0]  o_level,
    output logic [OUT_W-1:0]  o_depth
);

    logic [NQ_W-1:0]       r_num_q;
    logic                  r_two;
    logic [ADDR_W-1:0]     r_qa;
    logic [ADDR_W-1:0]     r_qb;
    logic [ERR_W-1:0]      r_err;
    logic [LEVEL_BITS-1:0] r_rd_a;
    logic [LEVEL_BITS-1:0] r_rd_b;
    logic                  r_rd_a_vld;
    logic                  r_rd_b_vld;
    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] r_depth;
    logic [QUBIT_SLOTS-1:0] r_vld;
    logic [LEVEL_BITS-1:0] r_mem [QUBIT_SLOTS];
    logic                  r_out_valid;
    logic [ERR_W-1:0]      r_out_err;
    logic [OUT_W-1:0]      r_out_level;
    logic [OUT_W-1:0]      r_out_depth;

    logic                  ok_a;
    logic                  ok_b;
    logic [ERR_W-1:0]      n_err;
    logic [LEVEL_BITS-1:0] m_a;
    logic [LEVEL_BITS-1:0] m_b;
    logic [LEVEL_BITS-1:0] m_max;
    logic [LEVEL_BITS-1:0] n_level;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [LEVEL_BITS-1:0] wr_data;

    // operand checks, range before distinctness
    always_comb begin
        ok_a = ({1'b0, i_qa} < {1'b0, r_num_q}) && ({1'b0, i_qa} < SLOTS_EXT);
        ok_b = ({1'b0, i_qb} < {1'b0, r_num_q}) && ({1'b0, i_qb} < SLOTS_EXT);
        if (!ok_a || (i_two && !ok_b)) begin
            n_err = ERR_RANGE;
        end else if (i_two && (i_qa == i_qb)) begin
            n_err = ERR_SAME;
        end else begin
            n_err = ERR_NONE;
        end
    end

    // level: one above the later frontier, the first alone for one-qubit gates, saturating
    always_comb begin
        m_a     = r_rd_a_vld ? r_rd_a : '0;
        m_b     = r_rd_b_vld ? r_rd_b : '0;
        m_max   = (r_two && (m_b > m_a)) ? m_b : m_a;
        n_level = (m_max == LEVEL_MAX) ? LEVEL_MAX : m_max + LEVEL_BITS'(1);
    end

    always_comb begin
        wr_en   = i_cmd.calc || i_cmd.wr2;
        wr_addr = i_cmd.wr2 ? r_qb : r_qa;
        wr_data = i_cmd.wr2 ? r_level : n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_q <= NQ_RESET;
        end else if (i_cfg_we) begin
            r_num_q <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_two <= i_two;
            r_qa  <= i_qa[ADDR_W-1:0];
            r_qb  <= i_qb[ADDR_W-1:0];
            r_err <= n_err;
        end
    end

    // frontier table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem[r_qa];
            r_rd_b <= r_mem[r_qb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_a_vld <= r_vld[r_qa];
                r_rd_b_vld <= r_vld[r_qb];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.calc && (n_level > r_depth)) begin
            r_depth <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_level <= n_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_err   <= r_err;
            r_out_level <= (r_err == ERR_NONE) ? OUT_W'(r_level) : '0;
            r_out_depth <= OUT_W'(r_depth);
        end
    end

    always_comb begin
        o_status.err_none = (r_err == ERR_NONE);
        o_status.two      = r_two;
        o_status.out_free = !r_out_valid || i_ready;
    end

    assign o_valid = r_out_valid;
    assign o_err   = r_out_err;
    assign o_level = r_out_level;
    assign o_depth = r_out_depth;

    `CDL_ASSERT_IF(a_reject_level_zero, r_out_valid && (r_out_err != ERR_NONE), r_out_level == '0, "rejected gate with nonzero level")
    `CDL_ASSERT_IF(a_level_within_depth, r_out_valid, r_out_level <= r_out_depth, "gate level above circuit depth")
    `CDL_ASSERT(a_depth_monotonic, 1'b1 |=> (r_depth >= $past(r_depth)), "circuit depth decreased")

endmodule

`default_nettype wire

// ===== rtl/core/circuit_depth_levelizer_core.sv =====
// sequence: input transfer, frontier read, level calculation, second write for a
// two-qubit gate only, then result loaded into the output register once it is free;
// a rejected gate skips calculation and writes; no new gate is taken until the
// result is loaded, as set by the sequential controller
// reset (synchronous, active low): frontier valid bits and depth cleared at
// once, qubit count back to 62, output empty; no clearing pass needed
`default_nettype none

module circuit_depth_levelizer_core import cdl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [NQ_W-1:0]        i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // qubit_first, qubit_second, zero pad
    input  logic [0:0]             s_axis_tuser,   // two_qubit
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // gate_level, circuit_depth
    output logic [ERR_W-1:0]       m_axis_tuser    // error_code
);

    t_cmd             cmd;
    t_status          status;
    logic [OUT_W-1:0] out_level;
    logic [OUT_W-1:0] out_depth;

    cdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cdl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_two       (s_axis_tuser[0]),
        .i_qa        (s_axis_tdata[QB_W-1:0]),
        .i_qb        (s_axis_tdata[2*QB_W-1:QB_W]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_err       (m_axis_tuser),
        .o_level     (out_level),
        .o_depth     (out_depth)
    );

    assign m_axis_tdata = {out_depth, out_level};

endmodule

`default_nettype wire
